// ===== design/crep_pkg.sv =====
// ----------------------------------------------------------------------------
// crep_pkg
// Shared types and constants of the cache replacement directory.
// ----------------------------------------------------------------------------
`default_nettype none

package crep_pkg;

  // Default storage geometry
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed port widths
  localparam int KEY_W         = 32;
  localparam int SLOT_BITS     = 4;
  localparam int ADDR_BITS     = 3;
  localparam int DATA_BITS     = 32;
  localparam int POLICY_BITS   = 2;
  localparam int CAPACITY_BITS = 5;

  // Register indexes (word address)
  localparam logic [ADDR_BITS-3:0] REG_POLICY   = 1'b0;
  localparam logic [ADDR_BITS-3:0] REG_CAPACITY = 1'b1;

  // Policy codes; any other code runs as FIFO
  localparam logic [POLICY_BITS-1:0] POL_FIFO  = 2'd0;
  localparam logic [POLICY_BITS-1:0] POL_LRU   = 2'd1;
  localparam logic [POLICY_BITS-1:0] POL_CLOCK = 2'd2;

  // Reset values of the registers
  localparam logic [POLICY_BITS-1:0]   POLICY_RESET   = POL_FIFO;
  localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 5'd16;

  typedef struct packed {
    logic [POLICY_BITS-1:0]   policy;
    logic [CAPACITY_BITS-1:0] capacity;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SRCH,
    ST_CMP,
    ST_ACT,
    ST_SH_RD,
    ST_SH_WR,
    ST_SWEEP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/crep_key_ram.sv =====
// ----------------------------------------------------------------------------
// crep_key_ram
// Key store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crep_key_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/crep_cfg.sv =====
// ----------------------------------------------------------------------------
// crep_cfg
// APB register file holding the replacement policy and the capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module crep_cfg
  import crep_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy   <= POLICY_RESET;
      cfg.capacity <= CAPACITY_RESET;
    end else if (wr_en) begin
      unique case (paddr[ADDR_BITS-1:2])
        REG_POLICY:   cfg.policy   <= pwdata[POLICY_BITS-1:0];
        REG_CAPACITY: cfg.capacity <= pwdata[CAPACITY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_BITS-1:2])
      REG_POLICY:   prdata = DATA_BITS'(cfg.policy);
      REG_CAPACITY: prdata = DATA_BITS'(cfg.capacity);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cache_replacement_fifo_lru_clock.sv =====
// Steps per item: fold the hand into the capacity, search the filled entries, then an LRU
//   move of the entries behind the hit or the oldest, or a CLOCK sweep over set bits.
// Flow: one item in flight; the next is accepted in the idle state after the result loads.
// Reset (synchronous): fill count, hand, reference bits and handshakes clear;
//   the key store is not cleared, entries past the fill count are never read.
// ----------------------------------------------------------------------------
// cache_replacement_fifo_lru_clock
// Fully associative directory with FIFO, LRU and CLOCK replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module cache_replacement_fifo_lru_clock
  import crep_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  input  wire logic                 key_valid,
  output logic                      key_ready,
  input  wire logic [KEY_W-1:0]     key,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic                      hit,
  output logic      [SLOT_BITS-1:0] slot
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  cfg_t cfg;

  state_t state, state_next;

  logic [KEY_BITS-1:0]    cur_key;
  logic [CW-1:0]          cur_cap;
  logic [POLICY_BITS-1:0] cur_policy;
  logic [CW-1:0]          fill_count;
  logic [IW-1:0]          hand;
  logic [MAX_ENTRIES-1:0] ref_bits;
  logic [CW-1:0]          scan_idx;
  logic                   found_hit;
  logic [IW-1:0]          found_idx;
  logic [IW-1:0]          shift_idx;
  logic [IW-1:0]          slot_sel;
  logic                   res_hit;
  logic [IW-1:0]          res_slot;

  logic                   mem_we;
  logic [IW-1:0]          mem_waddr;
  logic [KEY_BITS-1:0]    mem_wdata;
  logic [IW-1:0]          mem_raddr;
  logic [KEY_BITS-1:0]    mem_rdata;

  logic [CW-1:0]          cap_eff;
  logic [CW-1:0]          hand_inc;
  logic [IW-1:0]          hand_adv;
  logic                   full;
  logic                   is_lru;
  logic                   is_clock;
  logic                   hand_wrap;
  logic                   match;
  logic                   sh_more;
  logic                   accept;
  logic                   out_free;

  crep_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crep_key_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (KEY_BITS),
    .AW    (IW)
  ) u_key_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Clamp the configured capacity to 1..MAX_ENTRIES
  always_comb begin
    if (cfg.capacity == '0) begin
      cap_eff = CW'(1);
    end else if (int'(cfg.capacity) > MAX_ENTRIES) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = CW'(cfg.capacity);
    end
  end

  assign hand_inc  = CW'(hand) + CW'(1);
  assign hand_adv  = (hand_inc == cur_cap) ? '0 : IW'(hand_inc);
  assign hand_wrap = CW'(hand) >= cur_cap;
  assign full      = fill_count == cur_cap;
  assign is_lru    = cur_policy == POL_LRU;
  assign is_clock  = cur_policy == POL_CLOCK;
  assign match     = mem_rdata == cur_key;
  assign sh_more   = (CW'(shift_idx) + CW'(1)) < fill_count;
  assign key_ready = state == ST_IDLE;
  assign accept    = key_valid && key_ready;
  assign out_free  = !res_valid || res_ready;
  assign hit       = res_hit;
  assign slot      = SLOT_BITS'(res_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (key_valid) state_next = ST_NORM;
      ST_NORM:  if (!hand_wrap) state_next = ST_SRCH;
      ST_SRCH:  state_next = (scan_idx < fill_count) ? ST_CMP : ST_ACT;
      ST_CMP:   state_next = match ? ST_ACT : ST_SRCH;
      ST_ACT: begin
        if (is_lru && (found_hit || full)) begin
          state_next = ST_SH_RD;
        end else if (is_clock && !found_hit && full) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SH_RD: state_next = sh_more ? ST_SH_WR : ST_DONE;
      ST_SH_WR: state_next = ST_SH_RD;
      ST_SWEEP: if (!ref_bits[hand]) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Key store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = cur_key;
    mem_raddr = '0;
    unique case (state)
      ST_SRCH: mem_raddr = IW'(scan_idx);
      ST_ACT: begin
        if (!found_hit && !full) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(fill_count);
        end else if (!found_hit && !is_lru && !is_clock) begin
          mem_we    = 1'b1;
          mem_waddr = hand;
        end
      end
      ST_SH_RD: begin
        if (sh_more) begin
          mem_raddr = IW'(CW'(shift_idx) + CW'(1));
        end else begin
          mem_we    = 1'b1;
          mem_waddr = IW'(fill_count - CW'(1));
        end
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = shift_idx;
        mem_wdata = mem_rdata;
      end
      ST_SWEEP: begin
        if (!ref_bits[hand]) begin
          mem_we    = 1'b1;
          mem_waddr = hand;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      hand       <= '0;
      ref_bits   <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != ST_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && fill_count > cap_eff) begin
            fill_count <= cap_eff;
          end
        end
        ST_NORM: begin
          if (hand_wrap) begin
            hand <= hand - IW'(cur_cap);
          end
        end
        ST_ACT: begin
          if (!found_hit && !full) begin
            ref_bits[IW'(fill_count)] <= 1'b0;
            fill_count                <= fill_count + CW'(1);
          end else if (found_hit) begin
            if (is_clock) begin
              ref_bits[found_idx] <= 1'b1;
            end
          end else if (!is_lru && !is_clock) begin
            hand <= hand_adv;
          end
        end
        ST_SWEEP: begin
          ref_bits[hand] <= 1'b0;
          hand           <= hand_adv;
        end
        ST_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Per-item working registers and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_key    <= KEY_BITS'(key);
          cur_cap    <= cap_eff;
          cur_policy <= cfg.policy;
          scan_idx   <= '0;
          found_hit  <= 1'b0;
        end
      end
      ST_CMP: begin
        if (match) begin
          found_hit <= 1'b1;
          found_idx <= IW'(scan_idx);
        end else begin
          scan_idx <= scan_idx + CW'(1);
        end
      end
      ST_ACT: begin
        shift_idx <= found_hit ? found_idx : '0;
        if (!found_hit && !full) begin
          slot_sel <= IW'(fill_count);
        end else if (found_hit) begin
          slot_sel <= found_idx;
        end else begin
          slot_sel <= hand;
        end
      end
      ST_SH_RD: begin
        if (!sh_more) begin
          slot_sel <= IW'(fill_count - CW'(1));
        end
      end
      ST_SH_WR: shift_idx <= shift_idx + IW'(1);
      ST_SWEEP: begin
        if (!ref_bits[hand]) begin
          slot_sel <= hand;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_hit  <= found_hit;
          res_slot <= slot_sel;
        end
      end
      default: ;
    endcase
  end

  // One item in flight: no new item right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !key_ready)
    else $error("item accepted while another is in flight");

  // The fill count stays within the clamped capacity during the search
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH) |-> (fill_count <= cur_cap))
    else $error("fill count above capacity during search");

  // The clock hand stays inside the capacity while sweeping
  a_hand_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (CW'(hand) < cur_cap))
    else $error("clock hand outside capacity");

  // A finished item reaches the output register
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> res_valid && key_ready)
    else $error("finished item not presented");

endmodule

`default_nettype wire
